// ===== rtl/core/imucf_pkg.sv =====
// Shared constants, types and the CORDIC arctangent table for the attitude filter.
// No dependencies.
package imucf_pkg;
    localparam int CordicStepsDef = 16;
    localparam int TableLen = 24;
    localparam logic [16:0] GyroWeightRst = 17'd65470;
    localparam logic [23:0] SamplePeriodRst = 24'd83886;
    localparam logic [23:0] GyroScaleRst = 24'd8004;
    localparam logic [47:0] AccelScaleRst = 48'd70369817935872;
    localparam logic [16:0] OneQ16 = 17'd65536;

    localparam logic [2:0] RegGyroWeight = 3'd0;
    localparam logic [2:0] RegSamplePeriod = 3'd1;
    localparam logic [2:0] RegGyroScale = 3'd2;
    localparam logic [2:0] RegGyroBias = 3'd3;
    localparam logic [2:0] RegAccelBias = 3'd4;
    localparam logic [2:0] RegAccelScale = 3'd5;

    // one queued sample: corrected accel axes and raw gyro rates
    typedef struct packed {
        logic signed [33:0] ax;
        logic signed [33:0] ay;
        logic signed [33:0] az;
        logic signed [15:0] gp;
        logic signed [15:0] gr;
        logic signed [15:0] gy;
    } t_sample;

    // atan(2^-i) in degrees, Q16
    function automatic logic [21:0] atan_tab(input logic [4:0] i);
        case (i)
            5'd0: atan_tab = 22'd2949120;
            5'd1: atan_tab = 22'd1740967;
            5'd2: atan_tab = 22'd919879;
            5'd3: atan_tab = 22'd466945;
            5'd4: atan_tab = 22'd234379;
            5'd5: atan_tab = 22'd117304;
            5'd6: atan_tab = 22'd58666;
            5'd7: atan_tab = 22'd29335;
            5'd8: atan_tab = 22'd14668;
            5'd9: atan_tab = 22'd7334;
            5'd10: atan_tab = 22'd3667;
            5'd11: atan_tab = 22'd1833;
            5'd12: atan_tab = 22'd917;
            5'd13: atan_tab = 22'd458;
            5'd14: atan_tab = 22'd229;
            5'd15: atan_tab = 22'd115;
            5'd16: atan_tab = 22'd57;
            5'd17: atan_tab = 22'd29;
            5'd18: atan_tab = 22'd14;
            5'd19: atan_tab = 22'd7;
            5'd20: atan_tab = 22'd4;
            5'd21: atan_tab = 22'd2;
            5'd22: atan_tab = 22'd1;
            default: atan_tab = 22'd0;
        endcase
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) sat32 = 32'sh7FFFFFFF;
        else if (v < -64'sd2147483648) sat32 = 32'sh80000000;
        else sat32 = v[31:0];
    endfunction
endpackage

// ===== rtl/core/imu_complementary_attitude_filter_unit.sv =====
// Top level of the complementary attitude filter: config registers, front end, back end.
// Depends on imucf_pkg, imucf_front, imucf_back.
//
// channel  | direction | handshake               | payload
// s_axis   | in        | s_axis_tvalid/tready    | six signed 16-bit IMU fields
// m_axis   | out       | m_axis_tvalid/tready    | pitch, roll, yaw Q15.16
// cfg      | in        | i_cfg_valid/o_cfg_ready | 3-bit index, 48-bit data
//
// The back end handles one sample at a time, with the single shared CORDIC
// iterating both atan2 runs; an atan2 with both operands zero skips its
// iterations.
// The two-entry queue lets the front accept while the back works.
// Reset is synchronous, active low, clears estimates and config to defaults.
// The output register holds a result until m_axis_tready; the back stalls then.
module imu_complementary_attitude_filter_unit #(
    parameter int CORDIC_STEPS = imucf_pkg::CordicStepsDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // accel_x, accel_y, accel_z, gyro_pitch_raw, gyro_roll_raw, gyro_yaw_raw
    input  logic [95:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // pitch_angle, roll_angle, yaw_angle
    output logic [95:0] m_axis_tdata,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [47:0] i_cfg_data
);
    logic [16:0] r_gyro_weight;
    logic [23:0] r_sample_period, r_gyro_scale;
    logic [47:0] r_gyro_bias, r_accel_bias, r_accel_scale;
    logic               w_qv, w_pop;
    imucf_pkg::t_sample w_qd;

    assign o_cfg_ready = 1'b1;

    // register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gyro_weight <= imucf_pkg::GyroWeightRst;
            r_sample_period <= imucf_pkg::SamplePeriodRst;
            r_gyro_scale <= imucf_pkg::GyroScaleRst;
            r_gyro_bias <= '0;
            r_accel_bias <= '0;
            r_accel_scale <= imucf_pkg::AccelScaleRst;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                imucf_pkg::RegGyroWeight: r_gyro_weight <= i_cfg_data[16:0];
                imucf_pkg::RegSamplePeriod: r_sample_period <= i_cfg_data[23:0];
                imucf_pkg::RegGyroScale: r_gyro_scale <= i_cfg_data[23:0];
                imucf_pkg::RegGyroBias: r_gyro_bias <= i_cfg_data;
                imucf_pkg::RegAccelBias: r_accel_bias <= i_cfg_data;
                imucf_pkg::RegAccelScale: r_accel_scale <= i_cfg_data;
                default: ;
            endcase
        end
    end

    imucf_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_data(s_axis_tdata),
        .i_accel_bias(r_accel_bias), .i_accel_scale(r_accel_scale),
        .o_q_valid(w_qv), .i_q_pop(w_pop), .o_q_data(w_qd)
    );

    imucf_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_q_valid(w_qv), .o_q_pop(w_pop), .i_q_data(w_qd),
        .i_gyro_weight(r_gyro_weight), .i_sample_period(r_sample_period),
        .i_gyro_scale(r_gyro_scale), .i_gyro_bias(r_gyro_bias),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_data(m_axis_tdata)
    );

    // a pop only when the queue holds a sample
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_qv) else $error("pop from empty queue");
    // a stalled result holds its value
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed under stall");
endmodule

// ===== rtl/core/imucf_front.sv =====
// Front end: accepts samples, applies accel bias and scale, pushes to a two-entry queue.
// Depends on imucf_pkg.
module imucf_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [95:0]           i_data,
    input  logic [47:0]           i_accel_bias,
    input  logic [47:0]           i_accel_scale,
    output logic                  o_q_valid,
    input  logic                  i_q_pop,
    output imucf_pkg::t_sample    o_q_data
);
    imucf_pkg::t_sample r_q [2];
    logic               r_wp, r_rp;
    logic [1:0]         r_cnt;
    imucf_pkg::t_sample n_s;
    logic               w_push;

    // correct each accel axis: (raw - bias) * scale
    always_comb begin
        n_s.ax = ($signed({i_data[15], i_data[15:0]}) -
                  $signed({i_accel_bias[15], i_accel_bias[15:0]})) *
                 $signed({1'b0, i_accel_scale[15:0]});
        n_s.ay = ($signed({i_data[31], i_data[31:16]}) -
                  $signed({i_accel_bias[31], i_accel_bias[31:16]})) *
                 $signed({1'b0, i_accel_scale[31:16]});
        n_s.az = ($signed({i_data[47], i_data[47:32]}) -
                  $signed({i_accel_bias[47], i_accel_bias[47:32]})) *
                 $signed({1'b0, i_accel_scale[47:32]});
        n_s.gp = i_data[63:48];
        n_s.gr = i_data[79:64];
        n_s.gy = i_data[95:80];
    end

    assign o_ready   = (r_cnt != 2'd2);
    assign w_push    = i_valid && o_ready;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_data  = r_q[r_rp];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= n_s;
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (i_q_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, i_q_pop};
        end
    end
endmodule

// ===== rtl/core/imucf_back.sv =====
// Back end: shared CORDIC for two atan2 runs, gyro integration, blend, output register.
// Depends on imucf_pkg.
module imucf_back #(
    parameter int CORDIC_STEPS = imucf_pkg::CordicStepsDef
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    output logic                  o_q_pop,
    input  imucf_pkg::t_sample    i_q_data,
    input  logic [16:0]           i_gyro_weight,
    input  logic [23:0]           i_sample_period,
    input  logic [23:0]           i_gyro_scale,
    input  logic [47:0]           i_gyro_bias,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [95:0]           o_data
);
    typedef enum logic [3:0] {
        S_IDLE, S_CPRE, S_CITER, S_RATE, S_DT, S_BMUL, S_BSUM, S_OUT
    } t_state;

    t_state             r_state;
    imucf_pkg::t_sample r_s;
    logic               r_axis;      // 0 pitch, 1 roll
    logic [4:0]         r_i;
    logic signed [37:0] r_x, r_y;
    logic signed [31:0] r_ang;
    logic signed [31:0] r_acc [2];
    logic [1:0]         r_g;         // gyro axis for rate/dt steps
    logic signed [41:0] r_rate;
    logic signed [37:0] r_chg [3];   // unsaturated angle change, Q16 degrees
    logic signed [31:0] r_pitch, r_roll, r_yaw;
    logic signed [49:0] r_m1, r_m2;
    logic               r_valid;
    logic [95:0]        r_data;

    logic signed [37:0] w_dx, w_dy;
    logic signed [31:0] w_tab, w_ang_nx;
    logic signed [15:0] w_graw, w_gbias;
    logic [40:0]        w_mag;
    logic [64:0]        w_prod;
    logic [36:0]        w_q;
    logic signed [31:0] w_est;
    logic [16:0]        w_alpha;
    logic signed [63:0] w_bl;

    assign w_dx = r_y >>> r_i;
    assign w_dy = r_x >>> r_i;
    assign w_tab = $signed({10'd0, imucf_pkg::atan_tab(r_i)});
    assign w_ang_nx = (r_y >= 0) ? r_ang + w_tab : r_ang - w_tab;
    assign w_alpha = (i_gyro_weight > imucf_pkg::OneQ16) ? imucf_pkg::OneQ16 : i_gyro_weight;

    // select gyro axis
    always_comb begin
        case (r_g)
            2'd0: begin w_graw = r_s.gp; w_gbias = i_gyro_bias[15:0]; end
            2'd1: begin w_graw = r_s.gr; w_gbias = i_gyro_bias[31:16]; end
            default: begin w_graw = r_s.gy; w_gbias = i_gyro_bias[47:32]; end
        endcase
    end

    // |rate| * dt, rounded at bit 28
    assign w_mag  = r_rate[41] ? 41'(-r_rate) : r_rate[40:0];
    assign w_prod = 65'(w_mag) * 65'(i_sample_period);
    assign w_q    = 37'((w_prod + 65'd134217728) >> 28);
    assign w_est  = r_axis ? r_roll : r_pitch;
    assign w_bl   = 64'(r_m1 + r_m2 + 50'sd32768) >>> 16;

    assign o_q_pop = (r_state == S_IDLE) && i_q_valid;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    // sequence one sample at a time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_pitch <= '0;
            r_roll  <= '0;
            r_yaw   <= '0;
        end else begin
            if (r_valid && i_ready && r_state != S_OUT) r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_s <= i_q_data;
                        r_axis <= 1'b0;
                        r_state <= S_CPRE;
                    end
                end
                // quadrant fold before iterating
                S_CPRE: begin
                    logic signed [37:0] ix, iy;
                    ix = 38'(r_s.az);
                    iy = r_axis ? 38'(r_s.ay) : 38'(r_s.ax);
                    r_i <= '0;
                    if (ix < 0) begin
                        if (iy >= 0) begin
                            r_ang <= 32'sd5898240; r_x <= iy; r_y <= -ix;
                        end else begin
                            r_ang <= -32'sd5898240; r_x <= -iy; r_y <= ix;
                        end
                    end else begin
                        r_ang <= '0; r_x <= ix; r_y <= iy;
                    end
                    if (ix == 0 && iy == 0) begin
                        r_acc[r_axis] <= '0;
                        r_axis <= ~r_axis;
                        if (r_axis) begin r_g <= 2'd0; r_state <= S_RATE; end
                    end else begin
                        r_state <= S_CITER;
                    end
                end
                S_CITER: begin
                    if (r_y >= 0) begin
                        r_x <= r_x + w_dx; r_y <= r_y - w_dy;
                    end else begin
                        r_x <= r_x - w_dx; r_y <= r_y + w_dy;
                    end
                    r_ang <= w_ang_nx;
                    r_i <= r_i + 5'd1;
                    // last step: keep the angle and move to the next axis
                    if (r_i == 5'(CORDIC_STEPS - 1) || r_i == 5'(imucf_pkg::TableLen - 1)) begin
                        r_acc[r_axis] <= w_ang_nx;
                        r_axis <= ~r_axis;
                        if (r_axis) begin
                            r_g <= 2'd0;
                            r_state <= S_RATE;
                        end else begin
                            r_state <= S_CPRE;
                        end
                    end
                end
                // rate = raw * scale - bias << 12
                S_RATE: begin
                    r_rate <= 42'(w_graw * $signed({1'b0, i_gyro_scale})) -
                              (42'(w_gbias) <<< 12);
                    r_state <= S_DT;
                end
                S_DT: begin
                    r_chg[r_g] <= r_rate[41] ? -38'(w_q) : 38'(w_q);
                    if (r_g == 2'd2) begin
                        r_axis <= 1'b0;
                        r_state <= S_BMUL;
                    end else begin
                        r_g <= r_g + 2'd1;
                        r_state <= S_RATE;
                    end
                end
                S_BMUL: begin
                    logic signed [31:0] pr;
                    pr = imucf_pkg::sat32(64'(w_est) + 64'(r_chg[{1'b0, r_axis}]));
                    r_m1 <= $signed({1'b0, w_alpha}) * 50'(pr);
                    r_m2 <= $signed({1'b0, 17'(imucf_pkg::OneQ16 - w_alpha)}) *
                            50'(r_acc[r_axis]);
                    r_state <= S_BSUM;
                end
                S_BSUM: begin
                    if (r_axis) r_roll <= imucf_pkg::sat32(w_bl);
                    else r_pitch <= imucf_pkg::sat32(w_bl);
                    r_axis <= ~r_axis;
                    if (r_axis) begin
                        r_yaw <= imucf_pkg::sat32(64'(r_yaw) + 64'(r_chg[2]));
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_BMUL;
                    end
                end
                S_OUT: begin
                    if (!r_valid || i_ready) begin
                        r_valid <= 1'b1;
                        r_data <= {r_yaw, r_roll, r_pitch};
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
